FILE: design/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and helpers of the SBUS frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int STORE_DEPTH  = FRAME_BYTES - 1;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int NUM_CHANNELS = 16;
	localparam int IDX_W        = $clog2(NUM_CHANNELS);
	localparam int CH_W         = 11;
	localparam int BIT_W        = 8;

	localparam logic [7:0]        HEADER_RESET = 8'h0F;
	localparam logic [7:0]        FOOTER_ZERO  = 8'h00;
	localparam logic [7:0]        FOOTER_EIGHT = 8'h08;
	localparam logic [3:0]        FOOTER_NIB   = 4'h4;
	localparam logic [ADDR_W-1:0] FLAG_POS     = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] LAST_POS     = ADDR_W'(STORE_DEPTH);
	localparam logic [BIT_W-1:0]  CH_STEP      = BIT_W'(CH_W);

	typedef logic [7:0]       byte_t;
	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [IDX_W-1:0] idx_t;

	function automatic logic footer_ok(input byte_t f);
		return (f == FOOTER_ZERO) || (f == FOOTER_EIGHT) || (f[3:0] == FOOTER_NIB);
	endfunction

endpackage

FILE: design/sfr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ifs
// Handshake channels of the SBUS frame receiver: bytes, channels, config.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
	import sfr_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface sfr_chan_if;
	import sfr_pkg::*;
	logic  valid;
	logic  ready;
	idx_t  channel_index;
	chan_t channel_value;
	logic  digital_ch17;
	logic  digital_ch18;
	logic  link_lost;
	logic  failsafe_active;
	logic  last_of_frame;
	modport source (output valid, output channel_index, output channel_value,
		output digital_ch17, output digital_ch18, output link_lost,
		output failsafe_active, output last_of_frame, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input digital_ch17, input digital_ch18, input link_lost,
		input failsafe_active, input last_of_frame, output ready);
endinterface

interface sfr_cfg_if;
	import sfr_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/sbus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// SBUS frame decoder: collects a header-led 25-byte frame in a RAM, checks
// the footer and unpacks the sixteen 11-bit channels as a run of items.
// ----------------------------------------------------------------------------
// Timing: while a frame is collected one byte item is taken each cycle.
// After a good footer the decoder reads three RAM bytes per channel through
// the single registered read port, and it starts on the next channel only
// once the previous item is taken; no bytes are taken until the frame drains.
// Reset: the header register returns to 0x0F and the block waits for a
// header; the frame RAM is not cleared, since every entry is written first.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
	input logic clk,
	input logic arst_n,
	sfr_byte_if.sink   rx,
	sfr_chan_if.source chan,
	sfr_cfg_if.sink    cfg
);
	import sfr_pkg::*;

	// Receive collects bytes, read fetches one channel's three bytes, and
	// emit holds a finished channel item until the sink takes it.
	typedef enum logic [1:0] {
		S_RECV,
		S_READ,
		S_EMIT
	} state_t;

	state_t            state_q;
	byte_t             header_q;
	logic [ADDR_W-1:0] pos_q;      // 0 means hunting for a header
	logic [3:0]        flags_q;
	idx_t              ch_q;
	logic [BIT_W-1:0]  bit_q;      // first bit of the current channel
	logic [1:0]        rd_cnt_q;
	logic [15:0]       win_q;

	idx_t  out_idx_q;
	chan_t out_val_q;
	logic  out_last_q;

	logic              rx_take;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	byte_t             ram_rdata;
	logic [23:0]       window;
	logic [23:0]       shifted;

	// Configuration writes are always taken; they must be issued only while idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	assign rx.ready = (state_q == S_RECV);
	assign rx_take  = rx.valid && rx.ready;

	// Every byte after the header lands at its frame position less one.
	assign ram_we    = rx_take && (pos_q != '0);
	assign ram_waddr = pos_q - ADDR_W'(1);

	// The byte address of a channel is its bit offset divided by eight.
	assign ram_re    = (state_q == S_READ) && (rd_cnt_q != 2'd3);
	assign ram_raddr = bit_q[BIT_W-1:3] + ADDR_W'(rd_cnt_q);

	// On the last read cycle the third byte arrives straight from the RAM.
	assign window  = {ram_rdata, win_q};
	assign shifted = window >> bit_q[2:0];

	sfr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(rx.data_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RECV;
			header_q <= HEADER_RESET;
			pos_q    <= '0;
			ch_q     <= '0;
			bit_q    <= '0;
			rd_cnt_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				header_q <= cfg.data;
			end
			unique case (state_q)
				S_RECV: begin
					if (rx_take) begin
						if (pos_q == '0) begin
							if (rx.data_byte == header_q) begin
								pos_q <= ADDR_W'(1);
							end
						end else if (pos_q == LAST_POS) begin
							// The footer closes the frame whether or not it is good.
							pos_q <= '0;
							if (footer_ok(rx.data_byte)) begin
								state_q  <= S_READ;
								ch_q     <= '0;
								bit_q    <= '0;
								rd_cnt_q <= '0;
							end
						end else begin
							if (pos_q == FLAG_POS) begin
								flags_q <= rx.data_byte[3:0];
							end
							pos_q <= pos_q + ADDR_W'(1);
						end
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					unique case (rd_cnt_q)
						2'd0: begin
						end
						2'd1: begin
							win_q[7:0] <= ram_rdata;
						end
						2'd2: begin
							win_q[15:8] <= ram_rdata;
						end
						2'd3: begin
							out_idx_q  <= ch_q;
							out_val_q  <= shifted[CH_W-1:0];
							out_last_q <= (ch_q == idx_t'(NUM_CHANNELS - 1));
							state_q    <= S_EMIT;
						end
						default: begin
						end
					endcase
				end
				S_EMIT: begin
					if (chan.ready) begin
						if (out_last_q) begin
							state_q <= S_RECV;
						end else begin
							ch_q     <= ch_q + idx_t'(1);
							bit_q    <= bit_q + CH_STEP;
							rd_cnt_q <= '0;
							state_q  <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_RECV;
				end
			endcase
		end
	end

	assign chan.valid           = (state_q == S_EMIT);
	assign chan.channel_index   = out_idx_q;
	assign chan.channel_value   = out_val_q;
	assign chan.digital_ch17    = flags_q[0];
	assign chan.digital_ch18    = flags_q[1];
	assign chan.link_lost       = flags_q[2];
	assign chan.failsafe_active = flags_q[3];
	assign chan.last_of_frame   = out_last_q;

endmodule

FILE: design/sfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sim/tb_sbus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_receiver
// Self-checking bench for the SBUS frame receiver. Byte items are fed in
// through the byte channel: a few hand-built frames first, then random
// frames, truncated frames and line noise under several header settings
// and back-pressure mixes. A scoreboard decodes every accepted byte on its
// own and compares each channel item with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_sbus_frame_receiver;
	import sfr_pkg::*;

	// Generous cycle budget for the whole run.
	localparam int unsigned CYCLE_LIMIT   = 200000;
	// Idle cycles after the last expected item before the header is rewritten.
	localparam int          SETTLE_CYCLES = 12;
	// Frame-related byte items per random segment, and number of segments.
	localparam int          SEGMENT_ITEMS = 36;
	localparam int          NUM_SEGMENTS  = 6;
	// The flag byte follows the 22 bytes that hold the packed channels.
	localparam int          FLAG_INDEX    = NUM_CHANNELS * CH_W / 8;

	// One decoded channel item, as it appears on the output channel.
	typedef struct packed {
		idx_t  chan_idx;
		chan_t chan_val;
		logic  ch17;
		logic  ch18;
		logic  lost;
		logic  failsafe;
		logic  last_flag;
	} chan_result_t;

	// How the body of a generated frame is filled.
	typedef enum int {
		FILL_ZERO,
		FILL_ONES,
		FILL_MIX,
		FILL_RANDOM
	} body_fill_t;

	// Keeps its own copy of the header register, the byte position and the
	// frame store, and queues the sixteen channel items of every good frame.
	class channel_scoreboard;
		chan_result_t expected_q[$];
		byte_t        header_value = HEADER_RESET;
		int unsigned  position     = 0;
		byte_t        frame_store[STORE_DEPTH];
		int unsigned  mismatches   = 0;

		function void set_header(byte_t v);
			header_value = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// True if the byte would start or extend a frame rather than be dropped.
		function bit takes_part(byte_t b);
			return (position != 0) || (b == header_value);
		endfunction

		function void note_byte(byte_t b);
			logic [8*STORE_DEPTH-1:0] frame_bits;
			chan_result_t             r;
			byte_t                    flags;
			if (position == 0) begin
				if (b == header_value)
					position = 1;
				return;
			end
			frame_store[position - 1] = b;
			position++;
			if (position < FRAME_BYTES)
				return;
			position = 0;
			if (!(b == FOOTER_ZERO || b == FOOTER_EIGHT || b[3:0] == FOOTER_NIB))
				return;
			for (int i = 0; i < STORE_DEPTH; i++)
				frame_bits[8*i +: 8] = frame_store[i];
			flags = frame_store[FLAG_INDEX];
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				r.chan_idx  = idx_t'(ch);
				r.chan_val  = frame_bits[CH_W*ch +: CH_W];
				r.ch17      = flags[0];
				r.ch18      = flags[1];
				r.lost      = flags[2];
				r.failsafe  = flags[3];
				r.last_flag = (ch == NUM_CHANNELS - 1);
				expected_q.push_back(r);
			end
		endfunction

		function void check_result(chan_result_t got);
			chan_result_t want;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected item: idx %0d val %h flags %b%b%b%b last %b",
						got.chan_idx, got.chan_val, got.failsafe, got.lost, got.ch18,
						got.ch17, got.last_flag);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (got.chan_idx !== want.chan_idx || got.chan_val !== want.chan_val ||
					got.ch17 !== want.ch17 || got.ch18 !== want.ch18 ||
					got.lost !== want.lost || got.failsafe !== want.failsafe ||
					got.last_flag !== want.last_flag) begin
				if (mismatches < 10) begin
					$display("channel mismatch: exp idx %0d val %h fl %b%b%b%b last %b,",
						want.chan_idx, want.chan_val, want.failsafe, want.lost, want.ch18,
						want.ch17, want.last_flag);
					$display("                  got idx %0d val %h fl %b%b%b%b last %b",
						got.chan_idx, got.chan_val, got.failsafe, got.lost, got.ch18,
						got.ch17, got.last_flag);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sfr_byte_if rx_if ();
	sfr_chan_if chan_if ();
	sfr_cfg_if  cfg_if ();

	sbus_frame_receiver uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.chan   (chan_if),
		.cfg    (cfg_if)
	);

	channel_scoreboard sb;

	// Percentages of cycles in which the byte sender and the channel receiver
	// hold back. They change between segments of the run.
	int          src_idle_pct;
	int          sink_idle_pct;
	// Byte items in the current segment that started or extended a frame;
	// bytes dropped while waiting for a header are not counted.
	int unsigned frame_items;
	int unsigned cycle_count;

	always #5 clk = ~clk;

	// The receiver side: ready is redrawn every cycle, so stalls land on every
	// position of the drain, including the last item of a frame.
	always @(posedge clk) begin
		chan_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Output monitor. It runs at the same edge that the block samples, so it
	// sees the handshake values that were present just before the edge.
	always @(posedge clk) begin : chan_monitor
		chan_result_t got;
		if (arst_n === 1'b1 && chan_if.valid === 1'b1 && chan_if.ready === 1'b1) begin
			got.chan_idx  = chan_if.channel_index;
			got.chan_val  = chan_if.channel_value;
			got.ch17      = chan_if.digital_ch17;
			got.ch18      = chan_if.digital_ch18;
			got.lost      = chan_if.link_lost;
			got.failsafe  = chan_if.failsafe_active;
			got.last_flag = chan_if.last_of_frame;
			sb.check_result(got);
		end
	end

	// Offers one byte item and returns at the edge where it is taken. Valid is
	// lowered only for an idle cycle, so back-to-back items keep it high and
	// it never gets two assignments in one time step.
	task automatic send_byte(input byte_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid     <= 1'b1;
		rx_if.data_byte <= b;
		@(posedge clk);
		while (rx_if.ready !== 1'b1)
			@(posedge clk);
		if (sb.takes_part(b))
			frame_items++;
		sb.note_byte(b);
	endtask

	// Sends the current header followed by nbytes frame bytes. A full frame
	// has STORE_DEPTH bytes after the header: the channel bytes, the flag
	// byte and the footer. Fewer bytes leave the frame open, and whatever
	// comes next is taken as its data.
	task automatic send_frame(input body_fill_t fill, input byte_t flags,
			input byte_t footer, input int nbytes);
		byte_t b;
		send_byte(sb.header_value);
		for (int i = 0; i < nbytes; i++) begin
			if (i == FLAG_INDEX) begin
				b = flags;
			end else if (i == STORE_DEPTH - 1) begin
				b = footer;
			end else begin
				case (fill)
					FILL_ZERO: b = 8'h00;
					FILL_ONES: b = 8'hFF;
					// The header value inside a frame must be stored as plain data.
					FILL_MIX: b = (i % 3 == 0) ? sb.header_value : (i[0] ? 8'hAA : 8'h55);
					default: begin
						b = ($urandom_range(0, 15) == 0) ? sb.header_value : byte_t'($urandom);
					end
				endcase
			end
			send_byte(b);
		end
	endtask

	// Mostly accepted footers of all three kinds, now and then an arbitrary one.
	function automatic byte_t pick_footer();
		case ($urandom_range(0, 3))
			0: return FOOTER_ZERO;
			1: return FOOTER_EIGHT;
			2: return {4'($urandom), FOOTER_NIB};
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Brings the block back to rest: any open frame is filled up with random
	// bytes, then every expected channel item has to come out, and a settling
	// wait follows in case the block is still busy with a rejected frame.
	task automatic drain();
		while (sb.position != 0)
			send_byte(byte_t'($urandom));
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the header register through its own channel. Called only at rest.
	task automatic write_header(input byte_t v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.set_header(v);
	endtask

	// Watchdog: a hung handshake or a lost item ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		byte_t hdr_plan[NUM_SEGMENTS];
		int    pick;
		sb = new;
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.data_byte = 8'h00;
		chan_if.ready   = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.data     = 8'h00;
		src_idle_pct    = 36;
		sink_idle_pct   = 58;
		frame_items     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, using the header value left by reset. Line noise
		// while waiting for a header must be dropped without a result.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0E);
		// All channels at zero and at full scale, with no flags and all flags.
		send_frame(FILL_ZERO, 8'h00, FOOTER_ZERO, STORE_DEPTH);
		send_frame(FILL_ONES, 8'hFF, FOOTER_EIGHT, STORE_DEPTH);
		// Header bytes inside the frame body, footer with low nibble four.
		send_frame(FILL_MIX, 8'h05, 8'hF4, STORE_DEPTH);
		// A rejected footer must give nothing, and the next frame still works.
		send_frame(FILL_MIX, 8'h0A, 8'h09, STORE_DEPTH);
		send_frame(FILL_RANDOM, 8'h06, {4'h0, FOOTER_NIB}, STORE_DEPTH);

		// Random part. Each segment gets its own header value, the two
		// extremes among them; each pair of segments shares a back-pressure mix:
		// receiver-heavy idling first, sender-heavy second, none in the last two.
		hdr_plan[0] = 8'h00;
		hdr_plan[1] = 8'hFF;
		hdr_plan[2] = byte_t'($urandom);
		hdr_plan[3] = byte_t'($urandom);
		hdr_plan[4] = HEADER_RESET;
		hdr_plan[5] = byte_t'($urandom);
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			drain();
			write_header(hdr_plan[seg]);
			case (seg / 2)
				0: begin
					src_idle_pct  = 36;
					sink_idle_pct = 58;
				end
				1: begin
					src_idle_pct  = 58;
					sink_idle_pct = 36;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			frame_items = 0;
			while (frame_items < SEGMENT_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// Well-formed frame with random content.
					send_frame(FILL_RANDOM, byte_t'($urandom), pick_footer(), STORE_DEPTH);
				end else if (pick < 80) begin
					// Truncated frame; the following header lands in its body.
					send_frame(FILL_RANDOM, byte_t'($urandom), FOOTER_ZERO,
						$urandom_range(1, STORE_DEPTH - 1));
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom));
				end else begin
					send_frame(FILL_MIX, byte_t'($urandom), byte_t'($urandom), STORE_DEPTH);
				end
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
